// ----- hdl/gnfe_pkg.sv -----
// ----------------------------------------------------------------------------
// gnfe_pkg: shared types and constants of the noise floor estimator
// Request kinds, fixed widths, the acceptance margin and the floor clamp.
// ----------------------------------------------------------------------------
package gnfe_pkg;

    localparam int RSSI_W  = 9;
    localparam int FLOOR_W = 9;
    localparam int SUM_W   = 16;
    localparam int THR_W   = 8;
    localparam int CNT_OUT_W = 7;

    localparam logic signed [5:0]         SAMPLE_MARGIN = 6'sd14;
    localparam logic signed [FLOOR_W-1:0] FLOOR_MIN     = -9'sd120;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_TRIGGER = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_RESET   = 2'd3
    } req_type_t;

    typedef struct packed {
        logic                        channel_busy;
        logic                        published;
        logic [CNT_OUT_W-1:0]        sample_count;
        logic signed [FLOOR_W-1:0]   floor_dbm;
    } result_t;

endpackage

// ----- hdl/gnfe_floor_div.sv -----
// ----------------------------------------------------------------------------
// gnfe_floor_div: batch average to floor value
// Divides the signed sample sum by the batch size through a reciprocal
// multiply (truncated toward zero) and clamps the result at the floor minimum.
// ----------------------------------------------------------------------------
module gnfe_floor_div #(
    parameter int BATCH_SAMPLES = 64
) (
    input  logic signed [gnfe_pkg::SUM_W-1:0]   sum,
    output logic signed [gnfe_pkg::FLOOR_W-1:0] floor_value
);

    localparam int SW    = gnfe_pkg::SUM_W;
    localparam int SHIFT = SW + $clog2(BATCH_SAMPLES);
    localparam int MW    = SW + 1;
    localparam int PW    = SW + MW;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SHIFT) + 64'(BATCH_SAMPLES) - 64'd1)
                                          / 64'(BATCH_SAMPLES));

    logic                 neg;
    logic [SW-1:0]        mag;
    logic [PW-1:0]        prod;
    logic [PW-1:0]        prod_shr;
    logic [SW-1:0]        quot;
    logic signed [SW:0]   quot_s;

    always_comb
    begin
        neg      = sum[SW-1];
        mag      = neg ? SW'(-sum) : SW'(sum);
        prod     = PW'(mag) * PW'(RECIP);
        prod_shr = prod >> SHIFT;
        quot     = prod_shr[SW-1:0];
        quot_s   = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        if (quot_s < (SW+1)'(gnfe_pkg::FLOOR_MIN))
        begin
            floor_value = gnfe_pkg::FLOOR_MIN;
        end
        else
        begin
            floor_value = quot_s[gnfe_pkg::FLOOR_W-1:0];
        end
    end

endmodule

// ----- hdl/gnfe_core.sv -----
// ----------------------------------------------------------------------------
// gnfe_core: estimator state and per-request update
// Holds floor, batch count and sum; applies one request per accepted cycle
// and forms the result of that request.
// ----------------------------------------------------------------------------
module gnfe_core #(
    parameter int BATCH_SAMPLES = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  gnfe_pkg::req_type_t                  req_type,
    input  logic signed [gnfe_pkg::RSSI_W-1:0]   rssi,
    input  logic                                 in_rx,
    input  logic                                 receiving,
    input  logic signed [gnfe_pkg::THR_W-1:0]    busy_threshold,
    output gnfe_pkg::result_t                    result
);

    localparam int CW = $clog2(BATCH_SAMPLES + 1);
    localparam int SW = gnfe_pkg::SUM_W;
    localparam int FW = gnfe_pkg::FLOOR_W;
    localparam logic [CW-1:0] BATCH_FULL = CW'(BATCH_SAMPLES);

    logic signed [FW-1:0] floor_reg, floor_next;
    logic [CW-1:0]        count_reg, count_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic                 published;
    logic                 full;
    logic signed [SW:0]   sum_add;
    logic signed [SW-1:0] sum_sat;
    logic signed [10:0]   rssi_x;
    logic signed [FW-1:0] div_floor;

    gnfe_floor_div #(
        .BATCH_SAMPLES (BATCH_SAMPLES)
    ) u_div (
        .sum         (sum_reg),
        .floor_value (div_floor)
    );

    always_comb
    begin
        full    = (count_reg >= BATCH_FULL);
        rssi_x  = 11'(rssi);
        sum_add = (SW+1)'(sum_reg) + (SW+1)'(rssi);
        case (sum_add[SW:SW-1])
            2'b01:   sum_sat = {1'b0, {(SW-1){1'b1}}};
            2'b10:   sum_sat = {1'b1, {(SW-1){1'b0}}};
            default: sum_sat = sum_add[SW-1:0];
        endcase

        floor_next = floor_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        published  = 1'b0;
        case (req_type)
            gnfe_pkg::REQ_TICK:
            begin
                if (in_rx && !full)
                begin
                    if (!receiving && (rssi_x < 11'(floor_reg) + 11'(gnfe_pkg::SAMPLE_MARGIN)))
                    begin
                        sum_next   = sum_sat;
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (full && (sum_reg != '0))
                begin
                    floor_next = div_floor;
                    sum_next   = '0;
                    published  = 1'b1;
                end
            end
            gnfe_pkg::REQ_TRIGGER:
            begin
                if (full)
                begin
                    count_next = '0;
                    sum_next   = '0;
                end
            end
            gnfe_pkg::REQ_RESTART:
            begin
                count_next = '0;
                sum_next   = '0;
            end
            default:
            begin
                floor_next = '0;
                count_next = '0;
                sum_next   = '0;
            end
        endcase

        result.floor_dbm    = floor_next;
        result.sample_count = gnfe_pkg::CNT_OUT_W'(count_next);
        result.published    = published;
        result.channel_busy = (busy_threshold != '0)
                              && (rssi_x > 11'(floor_next) + 11'(busy_threshold));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (accept)
        begin
            floor_reg <= floor_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= BATCH_FULL)
        else $error("batch count above batch size");

    a_publish_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && published |-> full && (sum_reg != '0))
        else $error("floor published from a partial or empty batch");

    a_publish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && published |=> (sum_reg == '0) && (count_reg == $past(count_reg)))
        else $error("publish did not clear the sum");

    a_full_reset: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type == gnfe_pkg::REQ_RESET)
        |=> (floor_reg == '0) && (count_reg == '0) && (sum_reg == '0))
        else $error("full reset left state behind");

endmodule

// ----- hdl/gated_noise_floor_estimator.sv -----
// ----------------------------------------------------------------------------
// gated_noise_floor_estimator: RSSI noise floor estimator
// Batch-averages quiet RSSI samples into a clamped floor and flags a busy
// channel against a configurable margin.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per item: tuser holds the request kind (tick,
//   trigger, restart, reset), tdata holds RSSI and the receiver flags.
//   m_* returns exactly one result per request: floor, batch count, publish
//   flag and busy flag.
//   cfg_we/cfg_wdata write the busy threshold; write only while idle.
// Timing:
//   One request per cycle sustained while m_tready is high. State update and
//   result form as a request is taken, via one 16x17 reciprocal multiply
//   for the batch average; m_* shows the registered result in the cycle after.
// Reset and stall:
//   rst_n clears floor, count, sum, threshold and the output valid flag.
//   While m_tready is low a held result blocks s_tready only if the output
//   register is occupied; a result taken in the same cycle frees it for the
//   next request.
// ----------------------------------------------------------------------------
module gated_noise_floor_estimator #(
    parameter int BATCH_SAMPLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rssi[8:0], in_rx[9], receiving[10], zero[15:11]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // floor_dbm[8:0], sample_count[15:9],
                                   // published[16], channel_busy[17], zero[23:18]
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    logic                                    accept;
    logic                                    m_tvalid_reg;
    gnfe_pkg::result_t                       res_reg;
    gnfe_pkg::result_t                       res_next;
    logic signed [gnfe_pkg::THR_W-1:0]       threshold_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, res_reg};

    gnfe_core #(
        .BATCH_SAMPLES (BATCH_SAMPLES)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .req_type       (gnfe_pkg::req_type_t'(s_tuser)),
        .rssi           ($signed(s_tdata[8:0])),
        .in_rx          (s_tdata[9]),
        .receiving      (s_tdata[10]),
        .busy_threshold (threshold_reg),
        .result         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_we)
        begin
            threshold_reg <= $signed(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

endmodule
